// File: rtl/mwd_pkg.sv
// ============================================================================
// mwd_pkg
// Shared constants, types and register codes of the moving window
// deconvolution filter.
// ============================================================================
`default_nettype none

package mwd_pkg;

    // Delay line depths
    localparam int DIFF_DEPTH  = 8192;
    localparam int AVG_DEPTH   = 1024;
    localparam int DIFF_AW     = $clog2(DIFF_DEPTH);
    localparam int AVG_AW      = $clog2(AVG_DEPTH);
    localparam int DIFF_CNT_W  = $clog2(DIFF_DEPTH + 1);
    localparam int AVG_CNT_W   = $clog2(AVG_DEPTH + 1);

    // Number formats
    localparam int FRAC_BITS   = 16;
    localparam int ACC_W       = 48;
    localparam int OUT_W       = 48;
    localparam int SUM_W       = 64;
    localparam int SAMPLE_W    = 16;
    localparam int SCALE_SHIFT = 24;

    // Configuration register widths
    localparam int DECAY_W     = 32;
    localparam int DIFF_LEN_W  = 14;
    localparam int AVG_LEN_W   = 11;
    localparam int SCALE_W     = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Reset values
    localparam logic [DECAY_W-1:0]    DECAY_RST    = DECAY_W'(208014);
    localparam logic [DIFF_LEN_W-1:0] DIFF_LEN_RST = DIFF_LEN_W'(8000);
    localparam logic [AVG_LEN_W-1:0]  AVG_LEN_RST  = AVG_LEN_W'(1000);
    localparam logic [SCALE_W-1:0]    SCALE_RST    = SCALE_W'(16777);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd3;

    // Stream word widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 3 * OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIFF,
        ST_SUM,
        ST_WIN,
        ST_START,
        ST_WAIT,
        ST_OUT
    } mwd_state_t;

endpackage

`default_nettype wire

// File: rtl/mwd_ram.sv
// ============================================================================
// mwd_ram
// Simple dual-port synchronous RAM, one write port and one read port with
// registered read data.
// ============================================================================
`default_nettype none

module mwd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/mwd_scale.sv
// ============================================================================
// mwd_scale
// Window sum scaling: magnitude, two half-width multiplies on one shared
// multiplier, floor rounding and saturation to the output width.
// ============================================================================
`default_nettype none

module mwd_scale
    import mwd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] sum,
    input  wire logic [SCALE_W-1:0]      scale,
    output      logic                    done,
    output      logic [OUT_W-1:0]        result
);

    localparam int HALF   = SUM_W / 2;
    localparam int PROD_W = HALF + SCALE_W;
    localparam int HI_SH  = HALF - SCALE_SHIFT;
    localparam int Q_W    = OUT_W + HI_SH + 1;

    logic [3:0]          vld_reg;
    logic                done_reg;
    logic                neg_reg;
    logic [SUM_W-1:0]    mag_reg;
    logic [PROD_W-1:0]   lo_reg;
    logic [PROD_W-1:0]   hi_reg;
    logic [Q_W-1:0]      q_reg;
    logic                sat_reg;
    logic [OUT_W-1:0]    result_reg;

    logic [HALF-1:0]     mul_a;
    logic [PROD_W-1:0]   mul_p;
    logic                rem;
    logic [Q_W-1:0]      q_next;
    logic [OUT_W-1:0]    limit;
    logic [OUT_W-1:0]    qc;

    // share one multiplier between the low and the high half
    assign mul_a = vld_reg[0] ? mag_reg[HALF-1:0] : mag_reg[SUM_W-1:HALF];
    assign mul_p = PROD_W'(mul_a) * PROD_W'(scale);

    assign rem    = lo_reg[SCALE_SHIFT-1:0] != '0;
    assign q_next = (Q_W'(hi_reg[OUT_W-1:0]) << HI_SH)
                  + Q_W'(lo_reg >> SCALE_SHIFT)
                  + Q_W'(neg_reg && rem);

    assign limit = neg_reg ? (OUT_W'(1) << (OUT_W - 1))
                           : ((OUT_W'(1) << (OUT_W - 1)) - OUT_W'(1));
    assign qc    = (sat_reg || (q_reg > Q_W'(limit))) ? limit : q_reg[OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            vld_reg  <= {vld_reg[2:0], start};
            done_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= sum[SUM_W-1];
            mag_reg <= sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum)) : SUM_W'(sum);
        end
        if (vld_reg[0]) begin
            lo_reg <= mul_p;
        end
        if (vld_reg[1]) begin
            hi_reg <= mul_p;
        end
        if (vld_reg[2]) begin
            q_reg   <= q_next;
            sat_reg <= hi_reg[PROD_W-1:OUT_W] != '0;
        end
        if (vld_reg[3]) begin
            result_reg <= neg_reg ? (OUT_W'(0) - qc) : qc;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_single_job: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> vld_reg == '0 && !done_reg)
        else $error("scale unit restarted while busy");

endmodule

`default_nettype wire

// File: rtl/moving_window_deconvolution_filter.sv
// ============================================================================
// moving_window_deconvolution_filter
// Trapezoid-style pulse shaping of an ADC stream: deconvolution, delayed
// differentiation and moving average with saturated output.
// ============================================================================
// Each sample word taken on s_ gives one result word on m_ with the
// deconvolved accumulator, the difference to the accumulator diff_length
// samples back and the scaled window average, all with 16 fraction bits.
// As long as the result side takes words, s_tready drops at the accepting
// edge and rises again once the result has gone to the output register. The
// history RAM read, the accumulate and difference steps, the window RAM
// update and the shared scaling multiplier run one after another for each
// sample.
// A finished result waits in the output register while the next sample is
// worked on. Both delay lines read as zero until filled, so no clearing
// pass follows reset. Configuration writes are taken every cycle and belong
// in idle periods only.
`default_nettype none

module moving_window_deconvolution_filter
    import mwd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // samples
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,  // [15:0] sample
    // results
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_DATA_W-1:0]   m_tdata   // [47:0] deconvolved,
                                                 // [95:48] differentiated,
                                                 // [143:96] filtered
);

    localparam int PROD_W = SAMPLE_W + DECAY_W + 1;

    // configuration
    logic [DECAY_W-1:0]    decay_reg;
    logic [DIFF_LEN_W-1:0] diff_len_reg;
    logic [AVG_LEN_W-1:0]  avg_len_reg;
    logic [SCALE_W-1:0]    scale_reg;

    // control
    mwd_state_t            state_reg, state_next;
    logic [DIFF_AW-1:0]    hist_ptr_reg;
    logic [AVG_AW-1:0]     win_ptr_reg;
    logic [DIFF_CNT_W-1:0] hist_fill_reg;
    logic [AVG_CNT_W-1:0]  win_fill_reg;
    logic                  hist_ok_reg;
    logic                  win_ok_reg;
    logic                  m_tvalid_reg;

    // datapath
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W:0]   step_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           diff_reg;
    logic signed [ACC_W:0]      delta_reg;
    logic signed [SUM_W-1:0]    win_sum_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg;
    logic [SAMPLE_W-1:0]        s_tdata_hold;

    logic                  accept;
    logic                  out_free;
    logic                  hist_we;
    logic                  win_we;
    logic                  scl_start;
    logic                  out_load;
    logic [DIFF_CNT_W-1:0] dl;
    logic [AVG_CNT_W-1:0]  al;
    logic [ACC_W-1:0]      hist_rdata;
    logic [ACC_W-1:0]      win_rdata;
    logic [ACC_W-1:0]      old_acc;
    logic [ACC_W-1:0]      old_diff;
    logic                  scl_done;
    logic [OUT_W-1:0]      scl_result;
    logic [ACC_W-1:0]      acc_next;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg    <= DECAY_RST;
            diff_len_reg <= DIFF_LEN_RST;
            avg_len_reg  <= AVG_LEN_RST;
            scale_reg    <= SCALE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DECAY:    decay_reg    <= cfg_data[DECAY_W-1:0];
                CFG_DIFF_LEN: diff_len_reg <= cfg_data[DIFF_LEN_W-1:0];
                CFG_AVG_LEN:  avg_len_reg  <= cfg_data[AVG_LEN_W-1:0];
                CFG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // clamp lengths: zero acts as one
    assign dl = (diff_len_reg == '0) ? DIFF_CNT_W'(1)
              : (DIFF_CNT_W'(diff_len_reg) > DIFF_CNT_W'(DIFF_DEPTH)) ? DIFF_CNT_W'(DIFF_DEPTH)
              : DIFF_CNT_W'(diff_len_reg);
    assign al = (avg_len_reg == '0) ? AVG_CNT_W'(1)
              : (AVG_CNT_W'(avg_len_reg) > AVG_CNT_W'(AVG_DEPTH)) ? AVG_CNT_W'(AVG_DEPTH)
              : AVG_CNT_W'(avg_len_reg);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_ACC;
            ST_ACC:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_WIN;
            ST_WIN:   state_next = ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT:  if (scl_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        hist_we   = 1'b0;
        win_we    = 1'b0;
        scl_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_DIFF:  hist_we   = 1'b1;
            ST_SUM:   win_we    = 1'b1;
            ST_START: scl_start = 1'b1;
            ST_OUT:   out_load  = out_free;
            ST_ACC, ST_WIN, ST_WAIT: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hist_ptr_reg  <= '0;
            win_ptr_reg   <= '0;
            hist_fill_reg <= '0;
            win_fill_reg  <= '0;
            hist_ok_reg   <= 1'b0;
            win_ok_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            acc_reg       <= '0;
            prev_reg      <= '0;
            win_sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                // an entry reads as zero until it has been written
                hist_ok_reg <= dl <= hist_fill_reg;
                win_ok_reg  <= al <= win_fill_reg;
            end
            if (state_reg == ST_ACC) begin
                acc_reg  <= acc_next;
                prev_reg <= $signed(s_tdata_hold);
            end
            if (hist_we) begin
                hist_ptr_reg <= hist_ptr_reg + 1'b1;
                if (hist_fill_reg != DIFF_CNT_W'(DIFF_DEPTH)) begin
                    hist_fill_reg <= hist_fill_reg + 1'b1;
                end
            end
            if (win_we) begin
                win_ptr_reg <= win_ptr_reg + 1'b1;
                if (win_fill_reg != AVG_CNT_W'(AVG_DEPTH)) begin
                    win_fill_reg <= win_fill_reg + 1'b1;
                end
            end
            if (state_reg == ST_WIN) begin
                win_sum_reg <= win_sum_reg + SUM_W'(delta_reg);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign acc_next = acc_reg
                    + (ACC_W'(step_reg) << FRAC_BITS)
                    + ACC_W'(prod_reg >>> FRAC_BITS);

    assign old_acc  = hist_ok_reg ? hist_rdata : '0;
    assign old_diff = win_ok_reg ? win_rdata : '0;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s_tdata_hold <= s_tdata[SAMPLE_W-1:0];
            step_reg     <= $signed({s_tdata[SAMPLE_W-1], s_tdata[SAMPLE_W-1:0]})
                          - $signed({prev_reg[SAMPLE_W-1], prev_reg});
            prod_reg     <= prev_reg * $signed({1'b0, decay_reg});
        end
        if (hist_we) begin
            diff_reg <= acc_reg - old_acc;
        end
        if (win_we) begin
            delta_reg <= $signed({diff_reg[ACC_W-1], diff_reg})
                       - $signed({old_diff[ACC_W-1], old_diff});
        end
        if (out_load) begin
            m_tdata_reg <= {scl_result, diff_reg[OUT_W-1:0], acc_reg[OUT_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // delay lines
    // ------------------------------------------------------------------
    mwd_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DIFF_DEPTH)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (hist_ptr_reg),
        .wr_data (acc_reg),
        .rd_en   (accept),
        .rd_addr (hist_ptr_reg - dl[DIFF_AW-1:0]),
        .rd_data (hist_rdata)
    );

    mwd_ram #(
        .WIDTH (ACC_W),
        .DEPTH (AVG_DEPTH)
    ) u_win_ram (
        .aclk    (aclk),
        .wr_en   (win_we),
        .wr_addr (win_ptr_reg),
        .wr_data (diff_reg),
        .rd_en   (accept),
        .rd_addr (win_ptr_reg - al[AVG_AW-1:0]),
        .rd_data (win_rdata)
    );

    mwd_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scl_start),
        .sum     (win_sum_reg),
        .scale   (scale_reg),
        .done    (scl_done),
        .result  (scl_result)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_acc_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACC |-> $past(accept))
        else $error("accumulate step without an accepted sample");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        scl_done |-> state_reg == ST_WAIT)
        else $error("scaling result arrived outside the wait state");

    a_hist_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_fill_reg <= DIFF_CNT_W'(DIFF_DEPTH) && win_fill_reg <= AVG_CNT_W'(AVG_DEPTH))
        else $error("fill count beyond delay line depth");

    a_win_ptr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        win_we |=> win_ptr_reg == $past(win_ptr_reg) + 1'b1)
        else $error("window pointer did not advance once");

endmodule

`default_nettype wire

// File: tb/mwd_filter_checker.sv
// ============================================================================
// mwd_filter_checker
// Watches the configuration, sample and result channels of the moving window
// deconvolution filter, predicts every result word from its own copy of the
// filter state and compares it field by field with what the block returns.
// ============================================================================
`timescale 1ns / 1ps

module mwd_filter_checker
    import mwd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [15:0] sample
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_DATA_W-1:0]   m_tdata,   // [47:0] deconvolved,
                                                  // [95:48] differentiated,
                                                  // [143:96] filtered
    output int                         mismatches,
    output int                         outstanding,
    output int                         results_seen,
    output int                         saturated
);

    typedef struct packed {
        logic [OUT_W-1:0] filtered;
        logic [OUT_W-1:0] differentiated;
        logic [OUT_W-1:0] deconvolved;
    } mwd_word_t;

    localparam logic signed [95:0] FILT_HI = (96'sd1 <<< (OUT_W - 1)) - 96'sd1;
    localparam logic signed [95:0] FILT_LO = -(96'sd1 <<< (OUT_W - 1));

    // filter settings as last written
    logic [DECAY_W-1:0]      decay;
    logic [DIFF_LEN_W-1:0]   diff_len;
    logic [AVG_LEN_W-1:0]    avg_len;
    logic [SCALE_W-1:0]      scale;

    // filter state
    logic [ACC_W-1:0]        acc;
    logic [SAMPLE_W-1:0]     last_sample;
    logic [ACC_W-1:0]        acc_line  [DIFF_DEPTH];
    logic [ACC_W-1:0]        diff_line [AVG_DEPTH];
    logic signed [SUM_W-1:0] window_sum;
    int                      acc_wr;
    int                      diff_wr;

    mwd_word_t               expected_words [$];

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
        saturated    = 0;
    end

    task automatic clear_filter();
        decay       = DECAY_RST;
        diff_len    = DIFF_LEN_RST;
        avg_len     = AVG_LEN_RST;
        scale       = SCALE_RST;
        acc         = '0;
        last_sample = '0;
        window_sum  = '0;
        acc_wr      = 0;
        diff_wr     = 0;
        for (int i = 0; i < DIFF_DEPTH; i++) acc_line[i] = '0;
        for (int i = 0; i < AVG_DEPTH; i++) diff_line[i] = '0;
        expected_words.delete();
    endtask

    // Advance the filter by one sample and return the word it produces.
    function automatic mwd_word_t shape_sample(input logic [SAMPLE_W-1:0] x);
        logic signed [63:0] decay_term;
        logic [ACC_W-1:0]   old_acc;
        logic [ACC_W-1:0]   diff;
        logic [ACC_W-1:0]   old_diff;
        logic signed [95:0] scaled;
        int                 dl;
        int                 al;
        int                 rd;
        int                 ra;
        mwd_word_t          w;

        // 32 fraction bits down to FRAC_BITS, floor toward minus infinity
        decay_term = (longint'($signed(last_sample)) * longint'({32'd0, decay}))
                     >>> (32 - FRAC_BITS);
        acc = acc
              + ACC_W'((longint'($signed(x)) - longint'($signed(last_sample))) <<< FRAC_BITS)
              + ACC_W'(decay_term);
        last_sample = x;

        // zero acts as one, overlong lengths clamp to the line depth
        dl = (diff_len == 0) ? 1 : ((diff_len > DIFF_DEPTH) ? DIFF_DEPTH : int'(diff_len));
        rd = (acc_wr + DIFF_DEPTH - dl) % DIFF_DEPTH;
        old_acc = acc_line[rd];
        acc_line[acc_wr] = acc;
        acc_wr = (acc_wr + 1) % DIFF_DEPTH;
        diff = acc - old_acc;

        al = (avg_len == 0) ? 1 : ((avg_len > AVG_DEPTH) ? AVG_DEPTH : int'(avg_len));
        ra = (diff_wr + AVG_DEPTH - al) % AVG_DEPTH;
        old_diff = diff_line[ra];
        diff_line[diff_wr] = diff;
        diff_wr = (diff_wr + 1) % AVG_DEPTH;
        window_sum = window_sum + longint'($signed(diff)) - longint'($signed(old_diff));

        scaled = window_sum * $signed({1'b0, scale});
        scaled = scaled >>> SCALE_SHIFT;
        if (scaled > FILT_HI) begin
            scaled = FILT_HI;
        end else if (scaled < FILT_LO) begin
            scaled = FILT_LO;
        end

        w.deconvolved    = acc;
        w.differentiated = diff;
        w.filtered       = scaled[OUT_W-1:0];
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [OUT_W-1:0] want_v,
                                        input logic [OUT_W-1:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        mwd_word_t got;
        mwd_word_t want;
        if (!aresetn) begin
            clear_filter();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DECAY:    decay    = cfg_data[DECAY_W-1:0];
                    CFG_DIFF_LEN: diff_len = cfg_data[DIFF_LEN_W-1:0];
                    CFG_AVG_LEN:  avg_len  = cfg_data[AVG_LEN_W-1:0];
                    CFG_SCALE:    scale    = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            // retire the oldest word before queueing a new sample
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected: expected nothing, got %h",
                             $time, m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    results_seen++;
                    if (want.filtered == FILT_HI[OUT_W-1:0] ||
                        want.filtered == FILT_LO[OUT_W-1:0]) begin
                        saturated++;
                    end
                    check_field("deconvolved", want.deconvolved, got.deconvolved);
                    check_field("differentiated", want.differentiated, got.differentiated);
                    check_field("filtered", want.filtered, got.filtered);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_words = {expected_words, shape_sample(s_tdata)};
            end
            outstanding = expected_words.size();
        end
    end

endmodule

// File: tb/moving_window_deconvolution_filter_tb.sv
// ============================================================================
// moving_window_deconvolution_filter_tb
// Drives the moving window deconvolution filter with corner samples, a long
// saturating step run and random pulses under many register settings, with
// random stalls on both streams; the checker beside the block scores results.
// ============================================================================
`timescale 1ns / 1ps

module moving_window_deconvolution_filter_tb;
    import mwd_pkg::*;

    localparam int ITEMS       = 1600;
    localparam int HOLD_CYCLES = 400;
    localparam int LATENCY     = 12;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DECAY;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // [15:0] sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // [47:0] deconvolved, [95:48] differentiated,
                                             // [143:96] filtered

    bit steady     = 1'b0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int sent       = 0;
    int settings   = 0;

    int mismatches;
    int outstanding;
    int results_seen;
    int saturated;

    moving_window_deconvolution_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mwd_filter_checker mwd_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .saturated    (saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random back-pressure, a counted hold-off on request.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 17);
        end
    end

    function automatic logic [S_DATA_W-1:0] to_sample(input int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return S_DATA_W'(v);
    endfunction

    task automatic send_sample(input logic [S_DATA_W-1:0] x);
        if (!steady) begin
            while ($urandom_range(99) < 17) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Baseline, then a step with a stepwise decaying tail plus a little noise.
    task automatic send_pulse();
        int base;
        int amp;
        int lead;
        int len;
        int k;
        base = int'($urandom_range(400)) - 200;
        amp  = int'($urandom_range(60000)) - 30000;
        lead = $urandom_range(2, 6);
        len  = $urandom_range(6, 40);
        for (k = 0; k < lead; k++) begin
            send_sample(to_sample(base + int'($urandom_range(6)) - 3));
        end
        for (k = 0; k < len; k++) begin
            send_sample(to_sample(base + (amp >>> (k / 3)) + int'($urandom_range(6)) - 3));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // Fill the unused upper data bits with noise; the block must drop them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                             input int width);
        logic [31:0] mask;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (value & mask) | ($urandom() & ~mask);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [31:0] dec, input int dlen, input int alen,
                                 input logic [31:0] scl);
        wait_drained();
        write_reg(CFG_DECAY, dec, DECAY_W);
        write_reg(CFG_DIFF_LEN, dlen, DIFF_LEN_W);
        write_reg(CFG_AVG_LEN, alen, AVG_LEN_W);
        write_reg(CFG_SCALE, scl, SCALE_W);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [31:0] dec;
        logic [31:0] scl;
        int          dlen;
        int          alen;
        int          n;
        int          waited;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, full-scale corners and steps
        send_sample(16'h8000); send_sample(16'h7FFF); send_sample(16'h7FFF);
        send_sample(16'h7FFF); send_sample(16'h0000); send_sample(16'hFFFF);
        send_sample(16'h0001); send_sample(16'h8000); send_sample(16'h8000);
        send_sample(16'h5555); send_sample(16'hAAAA); send_sample(16'h0000);

        // zero decay, zero lengths acting as one, zero scale
        apply_setting(32'd0, 0, 0, 32'd0);
        send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h1234);
        send_sample(16'h8000);

        // full decay, shortest lengths, unity scale
        apply_setting(32'hFFFF_FFFF, 1, 1, 32'd1 << SCALE_SHIFT);
        send_sample(16'h8000); send_sample(16'h7FFF); send_sample(16'h8000);
        send_sample(16'h0000);

        // long full-scale steps drive the average into both saturation limits
        apply_setting(32'hFFFF_FFFF, 256, 256, (32'd1 << SCALE_W) - 32'd1);
        steady <= 1'b1;
        repeat (300) send_sample(16'h7FFF);
        repeat (400) send_sample(16'h8000);
        wait_drained();
        steady <= 1'b0;

        while (sent < ITEMS) begin
            case ($urandom_range(9))
                0:       dlen = 0;
                1:       dlen = DIFF_DEPTH;
                2:       dlen = $urandom_range(DIFF_DEPTH + 1, (1 << DIFF_LEN_W) - 1);
                default: dlen = $urandom_range(1, 64);
            endcase
            case ($urandom_range(9))
                0:       alen = 0;
                1:       alen = AVG_DEPTH;
                2:       alen = $urandom_range(AVG_DEPTH + 1, (1 << AVG_LEN_W) - 1);
                default: alen = $urandom_range(1, 32);
            endcase
            case ($urandom_range(7))
                0:       scl = 32'd0;
                1:       scl = (32'd1 << SCALE_W) - 32'd1;
                2:       scl = $urandom_range(1, (1 << SCALE_W) - 1);
                default: scl = (32'd1 << SCALE_SHIFT) / ((alen == 0) ? 1 :
                               ((alen > AVG_DEPTH) ? AVG_DEPTH : alen));
            endcase
            case ($urandom_range(7))
                0:       dec = 32'd0;
                1:       dec = 32'hFFFF_FFFF;
                2:       dec = $urandom();
                default: dec = $urandom_range(0, 2000000);
            endcase
            apply_setting(dec, dlen, alen, scl);
            // stall the result side while samples keep coming
            if (settings == 5 || $urandom_range(5) == 0) begin
                hold_token <= hold_token + 1;
            end
            n = sent + $urandom_range(60, 160);
            while (sent < n) begin
                if ($urandom_range(3) != 0) begin
                    send_pulse();
                end else begin
                    send_sample(S_DATA_W'($urandom()));
                end
            end
        end

        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(negedge aclk);
            waited++;
        end while (outstanding != 0 && waited < 20000);
        repeat (2 * LATENCY) @(posedge aclk);

        if (outstanding != 0) begin
            $display("%0d expected result words never arrived", outstanding);
        end
        $display("Ran %0d samples, %0d results, %0d register settings incl. clamped lengths",
                 sent, results_seen, settings);
        $display("and zero scale; %0d saturated averages, %0d-cycle result stalls",
                 saturated, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
